// ===== rtl/srtf_pkg.sv =====
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types and constants for the shortest-remaining-time scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int unsigned DEFAULT_MAX_JOBS  = 8;
  localparam int unsigned DEFAULT_TIME_BITS = 16;

  localparam int unsigned OPC_W     = 2;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned IN_TIME_W = 16;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned SUM_W     = 32;

  localparam logic [CNT_W-1:0] PCOUNT_RESET = 4'd1;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EXEC,
    ST_WAITC,
    ST_ACCUM,
    ST_RESP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic load;
    logic restart;
    logic scan_init;
    logic scan_issue;
    logic exec;
    logic idle_tick;
    logic calc_wait;
    logic accum;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
    logic found;
    logic will_finish;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/srtf_ctrl.sv =====
// ----------------------------------------------------------------------------
// srtf_ctrl
// Sequencer: accepts transactions and steps the datapath through a tick.
// ----------------------------------------------------------------------------
module srtf_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [srtf_pkg::OPC_W-1:0]    in_opcode_i,
  output logic                          in_ready_o,
  input  srtf_pkg::sts_t                sts_i,
  output srtf_pkg::cmd_t                cmd_o
);
  import srtf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_RESP;
          unique case (opcode_e'(in_opcode_i))
            OP_LOAD:    cmd_o.load = 1'b1;
            OP_TICK: begin
              cmd_o.scan_init = 1'b1;
              state_d         = ST_SCAN;
            end
            OP_RESTART: cmd_o.restart = 1'b1;
            OP_NOP:     ;
            default:    ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_EXEC;
      ST_EXEC: begin
        if (!sts_i.found) begin
          cmd_o.idle_tick = 1'b1;
          state_d         = ST_RESP;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = sts_i.will_finish ? ST_WAITC : ST_RESP;
        end
      end
      ST_WAITC: begin
        cmd_o.calc_wait = 1'b1;
        state_d         = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/srtf_dp.sv =====
// ----------------------------------------------------------------------------
// srtf_dp
// Job stores, minimum scan, time and sum arithmetic, output register.
// ----------------------------------------------------------------------------
module srtf_dp #(
  parameter int unsigned MAX_JOBS  = srtf_pkg::DEFAULT_MAX_JOBS,
  parameter int unsigned TIME_BITS = srtf_pkg::DEFAULT_TIME_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  srtf_pkg::cmd_t                  cmd_i,
  output srtf_pkg::sts_t                  sts_o,
  input  logic [srtf_pkg::SLOT_W-1:0]     in_slot_i,
  input  logic [srtf_pkg::IN_TIME_W-1:0]  in_arrival_i,
  input  logic [srtf_pkg::IN_TIME_W-1:0]  in_burst_i,
  input  logic                            cfg_we_i,
  input  logic [srtf_pkg::CNT_W-1:0]      cfg_wdata_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [srtf_pkg::SLOT_W-1:0]     out_ran_slot_o,
  output logic                            out_idle_o,
  output logic                            out_finished_o,
  output logic [srtf_pkg::SUM_W-1:0]      out_finish_time_o,
  output logic [srtf_pkg::SUM_W-1:0]      out_total_wait_o,
  output logic [srtf_pkg::SUM_W-1:0]      out_total_tat_o,
  output logic                            out_all_done_o
);
  import srtf_pkg::*;

  // Only eight slots are addressable by the slot field
  localparam int unsigned SLOTS = (MAX_JOBS < 8) ? MAX_JOBS : 8;
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned LD_W  = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;
  localparam int unsigned TAT_W = SUM_W + 1;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  logic [TIME_BITS-1:0] arr_mem [SLOTS];
  logic [TIME_BITS-1:0] bur_mem [SLOTS];
  logic [TIME_BITS-1:0] rem_mem [SLOTS];
  logic [SLOTS-1:0]     written_q;

  logic [IDX_W-1:0]     idx_q, rd_idx_q;
  logic                 rd_vld_q, rd_written_q;
  logic [TIME_BITS-1:0] rd_arr_q, rd_bur_q, rd_rem_q;

  logic                 found_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [TIME_BITS-1:0] best_arr_q, best_bur_q, best_rem_q;

  logic [SUM_W-1:0]     time_q, wsum_q, tsum_q;
  logic [CNT_W-1:0]     fcnt_q, pcnt_q;
  logic [TAT_W-1:0]     tat_q, wt_q;

  logic [SLOT_W-1:0]    res_slot_q;
  logic                 res_idle_q, res_fin_q;
  logic [SUM_W-1:0]     res_ftime_q;

  logic                 out_valid_q;

  logic                 load_ok, rem_we, cand, better, will_finish;
  logic [IDX_W-1:0]     ld_idx, rem_wa;
  logic [TIME_BITS-1:0] ld_arr, ld_bur, rem_wd;
  logic [SUM_W-1:0]     time_inc;
  logic [TAT_W+1:0]     wsum_add, tsum_add;

  // Load address and values, masked to the stored width
  assign load_ok = cmd_i.load && ({1'b0, in_slot_i} < (SLOT_W + 1)'(SLOTS));
  assign ld_idx  = in_slot_i[IDX_W-1:0];
  assign ld_arr  = TIME_BITS'(in_arrival_i[LD_W-1:0]);
  assign ld_bur  = TIME_BITS'(in_burst_i[LD_W-1:0]);

  assign rem_we = load_ok || cmd_i.exec;
  assign rem_wa = cmd_i.exec ? best_idx_q : ld_idx;
  assign rem_wd = cmd_i.exec ? (best_rem_q - TIME_BITS'(1)) : ld_bur;

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      arr_mem[ld_idx] <= ld_arr;
      bur_mem[ld_idx] <= ld_bur;
    end
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    if (cmd_i.scan_issue) begin
      rd_arr_q <= arr_mem[idx_q];
      rd_bur_q <= bur_mem[idx_q];
      rd_rem_q <= rem_mem[idx_q];
    end
  end

  // Unwritten slots read as having no work
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (load_ok) begin
      written_q[ld_idx] <= 1'b1;
    end
  end

  // Scan sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_issue;
      if (cmd_i.scan_init) begin
        idx_q <= '0;
      end else if (cmd_i.scan_issue) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_issue) begin
      rd_idx_q     <= idx_q;
      rd_written_q <= written_q[idx_q];
    end
  end

  // Runnable and strictly shorter: ties keep the lower slot
  assign cand   = rd_written_q && (rd_rem_q != '0) && (SUM_W'(rd_arr_q) <= time_q);
  assign better = cand && (!found_q || (rd_rem_q < best_rem_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.scan_init) begin
      found_q <= 1'b0;
    end else if (rd_vld_q && better) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && better) begin
      best_idx_q <= rd_idx_q;
      best_arr_q <= rd_arr_q;
      best_bur_q <= rd_bur_q;
      best_rem_q <= rd_rem_q;
    end
  end

  assign will_finish = (best_rem_q == TIME_BITS'(1));
  assign time_inc    = (time_q == SUM_MAX) ? SUM_MAX : time_q + SUM_W'(1);

  assign tsum_add = (TAT_W + 2)'(tsum_q) + (TAT_W + 2)'(tat_q);
  assign wsum_add = (TAT_W + 2)'(wsum_q) + (TAT_W + 2)'(wt_q);

  // Time, counts and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      fcnt_q <= '0;
      wsum_q <= '0;
      tsum_q <= '0;
      pcnt_q <= PCOUNT_RESET;
    end else begin
      if (cfg_we_i) begin
        pcnt_q <= cfg_wdata_i;
      end
      if (cmd_i.restart) begin
        time_q <= '0;
        fcnt_q <= '0;
        wsum_q <= '0;
        tsum_q <= '0;
      end else begin
        if (cmd_i.exec || cmd_i.idle_tick) begin
          time_q <= time_inc;
        end
        if (cmd_i.accum) begin
          tsum_q <= (tsum_add[TAT_W+1:SUM_W] != '0) ? SUM_MAX : tsum_add[SUM_W-1:0];
          wsum_q <= (wsum_add[TAT_W+1:SUM_W] != '0) ? SUM_MAX : wsum_add[SUM_W-1:0];
          if (fcnt_q != CNT_MAX) begin
            fcnt_q <= fcnt_q + CNT_W'(1);
          end
        end
      end
    end
  end

  // Completion arithmetic; turnaround uses the unsaturated end time
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      tat_q <= {1'b0, time_q} + TAT_W'(1) - TAT_W'(best_arr_q);
    end
    if (cmd_i.calc_wait) begin
      wt_q <= (tat_q > TAT_W'(best_bur_q)) ? (tat_q - TAT_W'(best_bur_q)) : '0;
    end
  end

  // Per-item result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_slot_q  <= '0;
      res_idle_q  <= 1'b0;
      res_fin_q   <= 1'b0;
      res_ftime_q <= '0;
    end else if (cmd_i.idle_tick) begin
      res_idle_q <= 1'b1;
    end else if (cmd_i.exec) begin
      res_slot_q  <= SLOT_W'(best_idx_q);
      res_fin_q   <= will_finish;
      res_ftime_q <= will_finish ? time_inc : '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_ran_slot_o    <= res_slot_q;
      out_idle_o        <= res_idle_q;
      out_finished_o    <= res_fin_q;
      out_finish_time_o <= res_ftime_q;
      out_total_wait_o  <= wsum_q;
      out_total_tat_o   <= tsum_q;
      out_all_done_o    <= (fcnt_q >= pcnt_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sts_o.scan_last   = (idx_q == IDX_W'(SLOTS - 1));
  assign sts_o.found       = found_q;
  assign sts_o.will_finish = will_finish;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/shortest_remaining_time_scheduler.sv =====
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler
// Preemptive shortest-remaining-time-first scheduler with turnaround and
// waiting-time accounting.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tuser opcode, tdata job
//  m_axis    out        m_axis_tvalid/m_axis_tready   tuser flags, tdata result
//  cfg       in         cfg_we_i (no wait)            process_count
//
//  A tick transaction scans S = min(MAX_JOBS, 8) slots: one slot of the
//  job stores is read per cycle over a single read port, then execute and
//  respond; a tick that completes a job adds a waiting-time subtract step
//  and a saturating accumulation step. Load, restart and no-operation
//  transactions go straight from acceptance to the response step.
//  Reset is asynchronous and active low; job stores need no clearing, a
//  per-slot written flag stands in for the zero remaining time.
//  The result register decouples the two sides: a new transaction is taken
//  while a result still waits on m_axis_tready; only the response step holds.
//
module shortest_remaining_time_scheduler #(
  parameter int unsigned MAX_JOBS  = srtf_pkg::DEFAULT_MAX_JOBS,
  parameter int unsigned TIME_BITS = srtf_pkg::DEFAULT_TIME_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] opcode
  input  logic [1:0]                    s_axis_tuser,
  // [2:0] slot, [18:3] arrival, [34:19] burst, [39:35] zero
  input  logic [39:0]                   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] idle, [1] finished
  output logic [1:0]                    m_axis_tuser,
  // [2:0] ran_slot, [34:3] finish_time, [66:35] total_wait,
  // [98:67] total_turnaround, [99] all_done, [103:100] zero
  output logic [103:0]                  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [srtf_pkg::CNT_W-1:0]    cfg_wdata_i
);
  import srtf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [SLOT_W-1:0] ran_slot;
  logic              idle, finished, all_done;
  logic [SUM_W-1:0]  finish_time, total_wait, total_tat;

  // Sequencer: owns the input handshake
  srtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: stores, scan, arithmetic and the result register
  srtf_dp #(
    .MAX_JOBS  (MAX_JOBS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_slot_i         (s_axis_tdata[2:0]),
    .in_arrival_i      (s_axis_tdata[18:3]),
    .in_burst_i        (s_axis_tdata[34:19]),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_ran_slot_o    (ran_slot),
    .out_idle_o        (idle),
    .out_finished_o    (finished),
    .out_finish_time_o (finish_time),
    .out_total_wait_o  (total_wait),
    .out_total_tat_o   (total_tat),
    .out_all_done_o    (all_done)
  );

  // Pack the result transaction
  assign m_axis_tuser = {finished, idle};
  assign m_axis_tdata = {4'b0000, all_done, total_tat, total_wait, finish_time, ran_slot};

  // The sequencer is not ready in the cycle after it accepts a transaction
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken on consecutive cycles");

  // An idle tick never reports a running or finished job
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (!m_axis_tuser[1] && (m_axis_tdata[2:0] == 3'd0)))
    else $error("idle result carries a job");

  // A completion always carries a non-zero end time
  a_finish_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[34:3] != 32'd0))
    else $error("completion with zero end time");

  // A result is shown only after the response step
  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(m_axis_tvalid)) |-> $past(cmd.out_load))
    else $error("result valid without a response step");

endmodule
